// ----- hdl/mmbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbc_pkg
// Shared types and constants for the multi-mode byte checksum core.
// ----------------------------------------------------------------------------
package mmbc_pkg;

    // Algorithm codes held in the algorithm register.
    localparam logic [1:0] ALG_BSD   = 2'd0;
    localparam logic [1:0] ALG_SYSV  = 2'd1;
    localparam logic [1:0] ALG_POSIX = 2'd2;
    localparam logic [1:0] ALG_CRC32 = 2'd3;

    // Configuration register indexes.
    localparam logic REG_ALGORITHM    = 1'b0;
    localparam logic REG_LEGACY_POSIX = 1'b1;

    // CRC polynomials and constants.
    localparam logic [31:0] POSIX_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] REFL_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    // Width of the reported byte count.
    localparam int BYTE_COUNT_W = 40;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        OP_BSD     = 3'd0,  // 16-bit rotate right by one, then add the byte
        OP_SUM     = 3'd1,  // 32-bit add of the byte
        OP_MSB_BIT = 3'd2,  // one MSB-first CRC bit step
        OP_LSB_BIT = 3'd3,  // one reflected CRC bit step
        OP_FOLD    = 3'd4   // fold upper half into lower half
    } alu_op_t;

    // Live configuration as seen by the sequencer.
    typedef struct packed {
        logic       legacy_posix_error;
        logic [1:0] algorithm;
    } cfg_t;

    // One finished result.
    typedef struct packed {
        logic                    failed;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic [31:0]             checksum;
    } result_t;

endpackage

// ----- hdl/mmbc_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbc_alu
// Shared arithmetic unit: one sum step, one CRC bit step or one fold per use.
// ----------------------------------------------------------------------------
module mmbc_alu (
    input  mmbc_pkg::alu_op_t op,
    input  logic [31:0]       value,
    input  logic [7:0]        operand,
    input  logic              bit_in,
    output logic [31:0]       result
);

    logic [15:0] rot16;
    logic [16:0] fold_sum;
    logic        fb_msb;
    logic        fb_lsb;

    assign rot16    = {value[0], value[15:1]};
    assign fold_sum = {1'b0, value[15:0]} + {1'b0, value[31:16]};
    assign fb_msb   = value[31] ^ bit_in;
    assign fb_lsb   = value[0] ^ bit_in;

    // Select the operation.
    always_comb begin
        case (op)
            mmbc_pkg::OP_BSD: begin
                result = {16'h0000, rot16 + {8'h00, operand}};
            end
            mmbc_pkg::OP_SUM: begin
                result = value + {24'h000000, operand};
            end
            mmbc_pkg::OP_MSB_BIT: begin
                result = {value[30:0], 1'b0} ^ (fb_msb ? mmbc_pkg::POSIX_POLY : 32'h0);
            end
            mmbc_pkg::OP_LSB_BIT: begin
                result = {1'b0, value[31:1]} ^ (fb_lsb ? mmbc_pkg::REFL_POLY : 32'h0);
            end
            mmbc_pkg::OP_FOLD: begin
                result = {15'h0000, fold_sum};
            end
            default: begin
                result = value;
            end
        endcase
    end

endmodule

// ----- hdl/mmbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbc_ctrl
// Sequencer that drives the shared unit over each byte, the SysV fold and
// the POSIX length append, and holds the running value and byte count.
// ----------------------------------------------------------------------------
module mmbc_ctrl #(
    parameter int COUNT_BITS = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_present,
    input  logic                in_eof,
    input  logic                in_err,
    input  mmbc_pkg::cfg_t      cfg,
    input  logic                restart,
    input  logic [1:0]          restart_alg,
    output logic                res_valid,
    input  logic                res_ready,
    output mmbc_pkg::result_t   res
);

    localparam int OUT_W = mmbc_pkg::BYTE_COUNT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BYTE = 5'b00010,
        S_FOLD = 5'b00100,
        S_LEN  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [31:0]             value_reg, value_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   len_reg, len_next;
    logic [7:0]              shift_reg, shift_next;
    logic [2:0]              bit_cnt_reg, bit_cnt_next;
    logic                    eof_pend_reg, eof_pend_next;
    mmbc_pkg::result_t       res_reg, res_next;

    mmbc_pkg::alu_op_t       alu_op;
    logic                    alu_bit;
    logic [31:0]             alu_out;

    mmbc_alu u_alu (
        .op      (alu_op),
        .value   (value_reg),
        .operand (shift_reg),
        .bit_in  (alu_bit),
        .result  (alu_out)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Next-state and datapath control.
    always_comb begin
        logic                        go_finish;
        logic                        done_now;
        logic                        done_failed;
        logic [31:0]                 done_sum;
        logic [COUNT_BITS-1:0]       len_shift;
        logic [OUT_W+COUNT_BITS-1:0] count_ext;

        go_finish     = 1'b0;
        done_now      = 1'b0;
        done_failed   = 1'b0;
        done_sum      = 32'h0;
        len_shift     = len_reg >> 8;
        count_ext     = '0;
        state_next    = state_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        eof_pend_next = eof_pend_reg;
        res_next      = res_reg;
        alu_op        = mmbc_pkg::OP_SUM;
        alu_bit       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_err) begin
                        done_now    = 1'b1;
                        done_failed = 1'b1;
                        done_sum    = (cfg.algorithm == mmbc_pkg::ALG_POSIX &&
                                       cfg.legacy_posix_error) ? mmbc_pkg::ALL_ONES : 32'h0;
                    end else if (in_present && count_reg != COUNT_MAX) begin
                        count_next    = count_reg + 1'b1;
                        shift_next    = in_byte;
                        eof_pend_next = in_eof;
                        bit_cnt_next  = 3'd0;
                        state_next    = S_BYTE;
                    end else if (in_eof) begin
                        go_finish = 1'b1;
                    end
                end
            end
            S_BYTE: begin
                logic byte_done;
                byte_done = 1'b0;
                case (cfg.algorithm)
                    mmbc_pkg::ALG_BSD: begin
                        alu_op    = mmbc_pkg::OP_BSD;
                        byte_done = 1'b1;
                    end
                    mmbc_pkg::ALG_SYSV: begin
                        alu_op    = mmbc_pkg::OP_SUM;
                        byte_done = 1'b1;
                    end
                    mmbc_pkg::ALG_POSIX: begin
                        alu_op       = mmbc_pkg::OP_MSB_BIT;
                        alu_bit      = shift_reg[7];
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        byte_done    = (bit_cnt_reg == 3'd7);
                    end
                    default: begin
                        alu_op       = mmbc_pkg::OP_LSB_BIT;
                        alu_bit      = shift_reg[0];
                        shift_next   = {1'b0, shift_reg[7:1]};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        byte_done    = (bit_cnt_reg == 3'd7);
                    end
                endcase
                value_next = alu_out;
                if (byte_done) begin
                    if (eof_pend_reg) begin
                        go_finish = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FOLD: begin
                alu_op       = mmbc_pkg::OP_FOLD;
                value_next   = alu_out;
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd1) begin
                    done_now = 1'b1;
                    done_sum = alu_out;
                end
            end
            S_LEN: begin
                alu_op       = mmbc_pkg::OP_MSB_BIT;
                alu_bit      = shift_reg[7];
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                value_next   = alu_out;
                if (bit_cnt_reg == 3'd7) begin
                    len_next = len_shift;
                    if (len_shift != '0) begin
                        shift_next = len_shift[7:0];
                    end else begin
                        done_now = 1'b1;
                        done_sum = ~alu_out;
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Start of the finishing pass once the last byte is in.
        if (go_finish) begin
            case (cfg.algorithm)
                mmbc_pkg::ALG_BSD: begin
                    done_now = 1'b1;
                    done_sum = {16'h0000, value_next[15:0]};
                end
                mmbc_pkg::ALG_SYSV: begin
                    bit_cnt_next = 3'd0;
                    state_next   = S_FOLD;
                end
                mmbc_pkg::ALG_POSIX: begin
                    if (count_next != '0) begin
                        len_next     = count_next;
                        shift_next   = count_next[7:0];
                        bit_cnt_next = 3'd0;
                        state_next   = S_LEN;
                    end else begin
                        done_now = 1'b1;
                        done_sum = ~value_next;
                    end
                end
                default: begin
                    done_now = 1'b1;
                    done_sum = value_next ^ mmbc_pkg::ALL_ONES;
                end
            endcase
        end

        // Capture the result and restart the file state.
        if (done_now) begin
            count_ext           = {{OUT_W{1'b0}}, count_next};
            res_next.checksum   = done_sum;
            res_next.byte_count = count_ext[OUT_W-1:0];
            res_next.failed     = done_failed;
            value_next          = (cfg.algorithm == mmbc_pkg::ALG_CRC32) ?
                                  mmbc_pkg::ALL_ONES : 32'h0;
            count_next          = '0;
            bit_cnt_next        = 3'd0;
            state_next          = S_DONE;
        end

        // An algorithm write restarts the current file.
        if (restart) begin
            value_next = (restart_alg == mmbc_pkg::ALG_CRC32) ? mmbc_pkg::ALL_ONES : 32'h0;
            count_next = '0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            value_reg    <= 32'h0;
            count_reg    <= '0;
            bit_cnt_reg  <= 3'd0;
            eof_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            value_reg    <= value_next;
            count_reg    <= count_next;
            bit_cnt_reg  <= bit_cnt_next;
            eof_pend_reg <= eof_pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    // The count is cleared whenever a result is waiting.
    a_done_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> count_reg == '0)
        else $error("byte count not cleared while a result waits");

    // The bit counter is back at zero whenever the sequencer is idle.
    a_idle_bit_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> bit_cnt_reg == 3'd0)
        else $error("bit counter left nonzero in idle");

    // The length append only runs while length bytes remain.
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LEN |-> len_reg != '0)
        else $error("length append running with zero length");

    // A read error produces a result on the next cycle.
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && in_err |=> state_reg == S_DONE && res_reg.failed)
        else $error("read error did not produce a failed result");

endmodule

// ----- hdl/multi_mode_byte_checksum_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_byte_checksum_core
// Byte-serial file checksum: BSD sum, SysV sum, POSIX cksum or CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   File bytes arrive one per beat on the s_ channel: s_tdata carries the
//   byte, s_tuser[0] says the byte is present and s_tuser[1] flags a read
//   error, s_tlast marks the last beat of a file. A beat with s_tlast or a
//   read error produces one result beat on the m_ channel: checksum and
//   byte count in m_tdata, m_tuser set when a read error ended the file.
//   The cfg_ channel writes the algorithm (index 0, restarts the file) and
//   the legacy POSIX error flag (index 1); write it only while idle.
// Timing:
//   A shared unit does one step per cycle. A byte beat takes one step for
//   BSD and SysV sums and one step per bit for the CRCs (one CRC bit per
//   cycle), and the block is not ready meanwhile. Finishing adds the SysV
//   fold steps, and one CRC step per bit of each nonzero length byte for
//   POSIX cksum; the result is then registered.
// Reset and stall:
//   aresetn clears the configuration and the file state. A result waits in
//   the output register while m_tready is low; the next file's bytes are
//   still taken until another result is ready to leave.
// ----------------------------------------------------------------------------
module multi_mode_byte_checksum_core #(
    parameter int COUNT_BITS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [0] byte_present, [1] read_error
    input  logic        s_tlast,    // end_of_file
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [31:0] checksum, [71:32] byte_count
    output logic        m_tuser,    // failed
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    logic [1:0]         algorithm_reg, algorithm_next;
    logic               legacy_reg, legacy_next;
    logic               restart;
    mmbc_pkg::cfg_t     cfg;
    logic               res_valid;
    logic               res_ready;
    mmbc_pkg::result_t  res;
    logic               m_tvalid_reg, m_tvalid_next;
    mmbc_pkg::result_t  out_reg;

    assign cfg_ready              = 1'b1;
    assign cfg.algorithm          = algorithm_reg;
    assign cfg.legacy_posix_error = legacy_reg;

    // Register writes.
    always_comb begin
        algorithm_next = algorithm_reg;
        legacy_next    = legacy_reg;
        restart        = 1'b0;
        if (cfg_valid) begin
            case (cfg_index)
                mmbc_pkg::REG_ALGORITHM: begin
                    algorithm_next = cfg_data;
                    restart        = 1'b1;
                end
                mmbc_pkg::REG_LEGACY_POSIX: begin
                    legacy_next = cfg_data[0];
                end
                default: begin
                    legacy_next = legacy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            algorithm_reg <= mmbc_pkg::ALG_BSD;
            legacy_reg    <= 1'b0;
        end else begin
            algorithm_reg <= algorithm_next;
            legacy_reg    <= legacy_next;
        end
    end

    mmbc_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_present  (s_tuser[0]),
        .in_eof      (s_tlast),
        .in_err      (s_tuser[1]),
        .cfg         (cfg),
        .restart     (restart),
        .restart_alg (cfg_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register: loads when empty or when its beat leaves.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.byte_count, out_reg.checksum};
    assign m_tuser  = out_reg.failed;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the multi-mode byte checksum core.
// ----------------------------------------------------------------------------
// Files of bytes go through all four checksum modes. The stimulus covers
// read errors, bare end markers, ignored beats and algorithm changes in the
// middle of a file. A tracker class recomputes each checksum from the
// accepted input beats. Every result beat is compared with the oldest
// outstanding sum. Both stream sides stall at random, and the receiver once
// holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int     CNT_BITS      = 40;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     RANDOM_ITEMS  = 2000;
    localparam longint TIMEOUT_NS    = 64'd20_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic [1:0]  s_tuser;     // [0] byte_present, [1] read_error
    logic        s_tlast;     // end_of_file
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;     // [31:0] checksum, [71:32] byte_count
    logic        m_tuser;     // failed
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [1:0]  cfg_data;

    // Tracks configuration and the open file, and holds the sums still owed.
    class file_checksum_tracker;
        logic [1:0]          alg;
        logic                legacy;
        logic [31:0]         acc;
        logic [CNT_BITS-1:0] seen;
        mmbc_pkg::result_t   expected_sums[$];
        int unsigned         errors;

        function new();
            alg    = mmbc_pkg::ALG_BSD;
            legacy = 1'b0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            acc  = (alg == mmbc_pkg::ALG_CRC32) ? mmbc_pkg::ALL_ONES : 32'd0;
            seen = '0;
        endfunction

        function logic [31:0] msb_first_step(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {b, 24'd0};
            for (int k = 0; k < 8; k++)
                c = c[31] ? ((c << 1) ^ mmbc_pkg::POSIX_POLY) : (c << 1);
            return c;
        endfunction

        function logic [31:0] reflected_step(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ mmbc_pkg::REFL_POLY) : (c >> 1);
            return c;
        endfunction

        function void absorb(logic [7:0] b);
            logic [15:0] s;
            case (alg)
                mmbc_pkg::ALG_BSD: begin
                    s   = {acc[0], acc[15:1]} + {8'd0, b};
                    acc = {16'd0, s};
                end
                mmbc_pkg::ALG_SYSV:  acc = acc + {24'd0, b};
                mmbc_pkg::ALG_POSIX: acc = msb_first_step(acc, b);
                default:             acc = reflected_step(acc, b);
            endcase
        endfunction

        function logic [31:0] finished_sum();
            logic [31:0]         v;
            logic [CNT_BITS-1:0] len;
            v = acc;
            case (alg)
                mmbc_pkg::ALG_BSD: v = {16'd0, acc[15:0]};
                mmbc_pkg::ALG_SYSV: begin
                    v = {16'd0, v[15:0]} + {16'd0, v[31:16]};
                    v = {16'd0, v[15:0]} + {16'd0, v[31:16]};
                end
                mmbc_pkg::ALG_POSIX: begin
                    // The length follows the data, low byte first.
                    for (len = seen; len != 0; len = len >> 8)
                        v = msb_first_step(v, len[7:0]);
                    v = ~v;
                end
                default: v = ~acc;
            endcase
            return v;
        endfunction

        function void configure(logic idx, logic [1:0] val);
            if (idx == mmbc_pkg::REG_ALGORITHM) begin
                alg = val;
                restart();
            end else begin
                legacy = val[0];
            end
        endfunction

        function void note_beat(logic [7:0] b, logic present, logic eof, logic err);
            mmbc_pkg::result_t r;
            if (err) begin
                r.checksum   = (alg == mmbc_pkg::ALG_POSIX && legacy) ?
                               mmbc_pkg::ALL_ONES : 32'd0;
                r.byte_count = seen;
                r.failed     = 1'b1;
                expected_sums.push_back(r);
                restart();
            end else begin
                // A saturated count freezes both the count and the sum.
                if (present && seen != '1) begin
                    absorb(b);
                    seen++;
                end
                if (eof) begin
                    r.checksum   = finished_sum();
                    r.byte_count = seen;
                    r.failed     = 1'b0;
                    expected_sums.push_back(r);
                    restart();
                end
            end
        endfunction

        function int unsigned pending();
            return expected_sums.size();
        endfunction

        task report(string what, logic [71:0] got, logic [71:0] want);
            errors++;
            $display("ERROR at %0t: %s got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_beat(logic [71:0] data, logic fail_flag);
            mmbc_pkg::result_t w;
            if (expected_sums.size() == 0) begin
                report("result beat with no sum outstanding, data", data, '0);
                return;
            end
            w = expected_sums.pop_front();
            if (data[31:0] !== w.checksum)
                report("checksum", 72'(data[31:0]), 72'(w.checksum));
            if (data[71:32] !== w.byte_count)
                report("byte_count", 72'(data[71:32]), 72'(w.byte_count));
            if (fail_flag !== w.failed)
                report("failed flag", 72'(fail_flag), 72'(w.failed));
        endtask
    endclass

    file_checksum_tracker sums = new();

    int unsigned counted_beats = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned rx_hold_len   = 0;

    multi_mode_byte_checksum_core #(
        .COUNT_BITS(CNT_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one input beat, wait for it to be taken, then maybe go idle.
    task automatic send_beat(logic [7:0] b, logic present, logic eof, logic err);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {err, present};
        s_tlast  <= eof;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sums.note_beat(b, present, eof, err);
        if (present || eof || err)
            counted_beats++;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // One file of random bytes, with the odd ignored beat mixed in.
    task automatic send_file(int unsigned len, bit ends_in_error);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, 1'b0, 1'b0);
        end
        if (ends_in_error)
            send_beat(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
        else
            send_beat(8'($urandom), ($urandom_range(0, 3) != 0), 1'b1, 1'b0);
    endtask

    // Stop sending, collect every outstanding result, then let the core settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sums.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sums.configure(idx, val);
        @(posedge aclk);
    endtask

    // Result side: check each beat taken and stall in bursts or on request.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                sums.check_beat(m_tdata, m_tuser);
            if (rx_hold_len != 0) begin
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Main sequence.
    initial begin : stimulus
        int unsigned n_files;
        int unsigned file_len;
        bit          last_stretch;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 20;
        rx_idle_pct = 20;

        // BSD sum: empty file by a bare end marker, extreme bytes, an ignored beat.
        send_beat(8'h5A, 1'b0, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        send_beat(8'h3C, 1'b0, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b1, 1'b0);

        // SysV sum.
        wait_idle();
        write_reg(mmbc_pkg::REG_ALGORITHM, mmbc_pkg::ALG_SYSV);
        send_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        send_beat(8'h01, 1'b1, 1'b1, 1'b0);

        // POSIX cksum with the legacy error code: the erroring byte is not counted,
        // and an error together with the end marker still reports an error.
        wait_idle();
        write_reg(mmbc_pkg::REG_ALGORITHM, mmbc_pkg::ALG_POSIX);
        write_reg(mmbc_pkg::REG_LEGACY_POSIX, 2'b11);
        send_beat(8'h31, 1'b1, 1'b0, 1'b0);
        send_beat(8'h77, 1'b1, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1, 1'b1);
        send_beat(8'h61, 1'b1, 1'b1, 1'b0);
        wait_idle();
        write_reg(mmbc_pkg::REG_LEGACY_POSIX, 2'b00);
        send_beat(8'h12, 1'b1, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0, 1'b1);

        // CRC-32; the legacy flag does not touch its error code.
        wait_idle();
        write_reg(mmbc_pkg::REG_ALGORITHM, mmbc_pkg::ALG_CRC32);
        write_reg(mmbc_pkg::REG_LEGACY_POSIX, 2'b01);
        send_beat(8'h31, 1'b1, 1'b0, 1'b0);
        send_beat(8'h32, 1'b1, 1'b0, 1'b0);
        send_beat(8'h33, 1'b1, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1, 1'b1);

        // An algorithm write in the middle of a file throws the open file away.
        send_beat(8'hAA, 1'b1, 1'b0, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0, 1'b0);
        wait_idle();
        write_reg(mmbc_pkg::REG_ALGORITHM, mmbc_pkg::ALG_BSD);
        send_beat(8'hFE, 1'b1, 1'b1, 1'b0);

        // Hold results back while short files keep coming, so the input backs up.
        rx_hold_len = 400;
        for (int i = 0; i < 6; i++)
            send_file($urandom_range(0, 3), 1'b0);
        wait_idle();

        // Random phases, each with its own settings and idling.
        counted_beats = 0;
        while (counted_beats < RANDOM_ITEMS) begin
            last_stretch = (counted_beats > RANDOM_ITEMS * 9 / 10);
            wait_idle();
            case ($urandom_range(0, 3))
                0: write_reg(mmbc_pkg::REG_ALGORITHM, 2'($urandom));
                1: write_reg(mmbc_pkg::REG_LEGACY_POSIX, 2'($urandom));
                default: begin
                    write_reg(mmbc_pkg::REG_ALGORITHM, 2'($urandom));
                    write_reg(mmbc_pkg::REG_LEGACY_POSIX, 2'($urandom));
                end
            endcase
            if (last_stretch) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 15 * $urandom_range(0, 2);
                rx_idle_pct = 15 * $urandom_range(0, 2);
            end
            n_files = $urandom_range(2, 10);
            repeat (n_files) begin
                // Long files now and then give POSIX a second length byte.
                file_len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 300)
                                                         : $urandom_range(0, 12);
                send_file(file_len, $urandom_range(0, 4) == 0);
            end
            // Sometimes leave a file open across the next register write.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    send_beat(8'($urandom), 1'b1, 1'b0, 1'b0);
        end

        wait_idle();
        if (sums.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
